[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/swid_pkg.sv]
// ----------------------------------------------------------------------------
// swid_pkg
// Types, status codes and defaults shared by the service-call divider.
// ----------------------------------------------------------------------------
package swid_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OUT_WIDTH      = 32;
    localparam int CALL_WIDTH     = 8;

    localparam logic [CALL_WIDTH-1:0] CALL_NUMBER_RESET = 8'd6;
    localparam int CALL_LSB_WORD = 16;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_UNIMPL  = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    // Per-transaction control that travels alongside the divider data.
    typedef struct packed {
        logic                  neg_q;
        logic                  neg_r;
        logic [1:0]            status;
        logic [CALL_WIDTH-1:0] call_number;
    } swid_side_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0]  quotient;
        logic [OUT_WIDTH-1:0]  remainder;
        logic [OUT_WIDTH-1:0]  abs_quotient;
        logic [1:0]            status;
        logic [CALL_WIDTH-1:0] call_number;
    } swid_result_t;

endpackage

[design/swid_front.sv]
// ----------------------------------------------------------------------------
// swid_front
// Decode the call number, classify the call and register operand magnitudes.
// ----------------------------------------------------------------------------
module swid_front import swid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [CALL_WIDTH-1:0]         call_sel,
    input  logic                          compact_mode,
    input  logic [31:0]                   instr_word,
    input  logic signed [OUT_WIDTH-1:0]   dividend,
    input  logic signed [OUT_WIDTH-1:0]   divisor,
    output logic                          out_valid,
    output swid_side_t                    out_side,
    output logic [DATA_WIDTH-1:0]         out_num,
    output logic [DATA_WIDTH-1:0]         out_rem,
    output logic [DATA_WIDTH-1:0]         out_den
);

    logic [DATA_WIDTH-1:0] num_w;
    logic [DATA_WIDTH-1:0] den_w;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [CALL_WIDTH-1:0] call_no;
    swid_side_t            side_next;

    logic                  valid_reg;
    swid_side_t            side_reg;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;

    always_comb begin
        // Sign-extend or truncate the operands to the datapath width.
        num_w   = DATA_WIDTH'(dividend);
        den_w   = DATA_WIDTH'(divisor);
        num_mag = num_w[DATA_WIDTH-1] ? (~num_w + 1'b1) : num_w;
        den_mag = den_w[DATA_WIDTH-1] ? (~den_w + 1'b1) : den_w;
        call_no = compact_mode ? instr_word[CALL_WIDTH-1:0]
                               : instr_word[CALL_LSB_WORD +: CALL_WIDTH];

        side_next.neg_q       = num_w[DATA_WIDTH-1] ^ den_w[DATA_WIDTH-1];
        side_next.neg_r       = num_w[DATA_WIDTH-1];
        side_next.call_number = call_no;
        if (call_no != call_sel) begin
            side_next.status = ST_UNIMPL;
        end else if (den_mag == '0) begin
            side_next.status = ST_DIVZERO;
        end else begin
            side_next.status = ST_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg <= side_next;
            num_reg  <= num_mag;
            den_reg  <= den_mag;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_num   = num_reg;
    assign out_rem   = '0;
    assign out_den   = den_reg;

endmodule

[design/swid_cell.sv]
// ----------------------------------------------------------------------------
// swid_cell
// One restoring-division step: settle one quotient bit and pass on.
// ----------------------------------------------------------------------------
module swid_cell import swid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  swid_side_t            in_side,
    input  logic [DATA_WIDTH-1:0] in_num,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_den,
    output logic                  out_valid,
    output swid_side_t            out_side,
    output logic [DATA_WIDTH-1:0] out_num,
    output logic [DATA_WIDTH-1:0] out_rem,
    output logic [DATA_WIDTH-1:0] out_den
);

    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic                  take;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] num_next;

    logic                  valid_reg;
    swid_side_t            side_reg;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] den_reg;

    always_comb begin
        // Bring down the next dividend bit, then try to subtract.
        rem_shift = {in_rem, in_num[DATA_WIDTH-1]};
        diff      = rem_shift - {1'b0, in_den};
        take      = ~diff[DATA_WIDTH];
        rem_next  = take ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
        // Quotient bits fill in from the bottom as dividend bits leave the top.
        num_next  = {in_num[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg <= in_side;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;

endmodule

[design/swid_fixup.sv]
// ----------------------------------------------------------------------------
// swid_fixup
// Restore result signs and clear the data fields of failed calls.
// ----------------------------------------------------------------------------
module swid_fixup import swid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  swid_side_t            side,
    input  logic [DATA_WIDTH-1:0] quot_mag,
    input  logic [DATA_WIDTH-1:0] rem_mag,
    output swid_result_t          result
);

    logic [DATA_WIDTH-1:0] quot_s;
    logic [DATA_WIDTH-1:0] rem_s;
    logic                  ok;

    always_comb begin
        quot_s = side.neg_q ? (~quot_mag + 1'b1) : quot_mag;
        rem_s  = side.neg_r ? (~rem_mag + 1'b1) : rem_mag;
        ok     = (side.status == ST_DONE);

        result.quotient     = ok ? OUT_WIDTH'(quot_s)   : '0;
        result.remainder    = ok ? OUT_WIDTH'(rem_s)    : '0;
        result.abs_quotient = ok ? OUT_WIDTH'(quot_mag) : '0;
        result.status       = side.status;
        result.call_number  = side.call_number;
    end

endmodule

[design/swid_divide_service.sv]
// ----------------------------------------------------------------------------
// swi_divide_service
// Pipelined signed divide service for software-interrupt calls.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per call (mode flag, instruction word and
//   the two operands). m_* channel: one result per call, in order: quotient,
//   remainder, absolute quotient, status and the decoded call number.
//   cfg_* channel: writes the call number that selects the divide service;
//   cfg_ready is always high. Write it only while no call is in flight.
// Pipeline: one decode stage, one cell per quotient bit and one output
//   register lie between input accept and m_valid.
// Throughput: one transaction per cycle unless stalled; each cell resolves one
//   quotient bit, so a new call enters behind the previous one every cycle.
// Stall: an output register plus a one-entry skid buffer sit at the end of
//   the chain. A stalled cycle on m_ready with a result leaving the chain
//   parks it in the skid; the chain and s_ready then freeze from the next
//   cycle until the output is taken and the skid drains into it.
// Reset (aresetn low, synchronous): all valid bits clear, the chain empties,
//   and the divide call number returns to 6.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swi_divide_service import swid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CALL_WIDTH-1:0]       cfg_data,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_compact_mode,
    input  logic [31:0]                 s_instr_word,
    input  logic signed [OUT_WIDTH-1:0] s_dividend,
    input  logic signed [OUT_WIDTH-1:0] s_divisor,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_WIDTH-1:0] m_quotient,
    output logic signed [OUT_WIDTH-1:0] m_remainder,
    output logic [OUT_WIDTH-1:0]        m_abs_quotient,
    output logic [1:0]                  m_status,
    output logic [CALL_WIDTH-1:0]       m_call_number
);

    localparam int NCELL = DATA_WIDTH;

    logic [CALL_WIDTH-1:0] call_sel_reg;

    // Chain taps: index 0 is the decode stage, index k+1 is after cell g_cell[k].
    logic                  chain_valid [NCELL+1];
    swid_side_t            chain_side  [NCELL+1];
    logic [DATA_WIDTH-1:0] chain_num   [NCELL+1];
    logic [DATA_WIDTH-1:0] chain_rem   [NCELL+1];
    logic [DATA_WIDTH-1:0] chain_den   [NCELL+1];

    logic         advance;
    swid_result_t fixed;

    logic         out_valid_reg;
    swid_result_t out_reg;
    logic         skid_valid_reg;
    swid_result_t skid_reg;

    // Configuration register: always ready, take the write on handshake.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            call_sel_reg <= CALL_NUMBER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            call_sel_reg <= cfg_data;
        end
    end

    // The whole chain moves together; hold it only while the skid is full.
    assign advance = ~skid_valid_reg;
    assign s_ready = advance;

    swid_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_valid     (s_valid),
        .call_sel     (call_sel_reg),
        .compact_mode (s_compact_mode),
        .instr_word   (s_instr_word),
        .dividend     (s_dividend),
        .divisor      (s_divisor),
        .out_valid    (chain_valid[0]),
        .out_side     (chain_side[0]),
        .out_num      (chain_num[0]),
        .out_rem      (chain_rem[0]),
        .out_den      (chain_den[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        swid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[k]),
            .in_side   (chain_side[k]),
            .in_num    (chain_num[k]),
            .in_rem    (chain_rem[k]),
            .in_den    (chain_den[k]),
            .out_valid (chain_valid[k+1]),
            .out_side  (chain_side[k+1]),
            .out_num   (chain_num[k+1]),
            .out_rem   (chain_rem[k+1]),
            .out_den   (chain_den[k+1])
        );
    end

    // Apply signs and error zeroing to what leaves the last cell.
    swid_fixup #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fixup (
        .side     (chain_side[NCELL]),
        .quot_mag (chain_num[NCELL]),
        .rem_mag  (chain_rem[NCELL]),
        .result   (fixed)
    );

    // Output register with a one-entry skid buffer behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // Chain frozen: drain the skid once the output is taken.
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= chain_valid[NCELL];
        end else if (chain_valid[NCELL]) begin
            // Output still waiting: park the arriving result.
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_reg <= fixed;
        end else begin
            skid_reg <= fixed;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_quotient     = out_reg.quotient;
    assign m_remainder    = out_reg.remainder;
    assign m_abs_quotient = out_reg.abs_quotient;
    assign m_status       = out_reg.status;
    assign m_call_number  = out_reg.call_number;

    // A parked result always sits behind a waiting output.
    `ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid full with empty output")
    // Failed calls carry no arithmetic result.
    `ASSERT_IMPLIES(a_error_zero, aclk, aresetn, m_valid && (m_status != ST_DONE), (m_quotient == '0) && (m_remainder == '0) && (m_abs_quotient == '0), "nonzero data on failed call")
    // A completed divide was selected by the configured call number.
    `ASSERT_IMPLIES(a_done_call, aclk, aresetn, m_valid && (m_status == ST_DONE), m_call_number == call_sel_reg, "done status for wrong call number")
    // A stalled output with a free skid parks the arriving result and drops s_ready.
    `ASSERT_NEXT(a_skid_fill, aclk, aresetn, !skid_valid_reg && out_valid_reg && !m_ready && chain_valid[NCELL], skid_valid_reg && !s_ready, "result not parked on stall")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for swi_divide_service: drives random and corner-case
// divide calls with random idling on both channels. Every accepted result is
// compared field by field against an in-order prediction built at the moment
// the call transaction is accepted.
// ----------------------------------------------------------------------------
module testbench;
    import swid_pkg::*;

    localparam int LATENCY     = DATA_WIDTH_DEF + 2;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 110;

    localparam logic [OUT_WIDTH-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [OUT_WIDTH-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_WIDTH-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    // Tracks the divide call select and the results still owed by the block.
    class divide_call_tracker;
        swid_result_t          answers_due[$];
        logic [CALL_WIDTH-1:0] call_sel;
        int                    errors;

        function new();
            call_sel = CALL_NUMBER_RESET;
            errors   = 0;
        endfunction

        // Work out the response of one call: decode, then signed divide
        // through magnitudes so the most negative operand wraps naturally.
        function swid_result_t divide_outcome(logic compact, logic [31:0] word,
                                              logic [OUT_WIDTH-1:0] dvd,
                                              logic [OUT_WIDTH-1:0] dvs);
            swid_result_t          res;
            logic [CALL_WIDTH-1:0] num;
            logic                  n_neg;
            logic                  d_neg;
            logic [OUT_WIDTH-1:0]  n_mag;
            logic [OUT_WIDTH-1:0]  d_mag;
            logic [OUT_WIDTH-1:0]  q_mag;
            logic [OUT_WIDTH-1:0]  r_mag;
            num = compact ? word[CALL_WIDTH-1:0] : word[CALL_LSB_WORD +: CALL_WIDTH];
            res = '0;
            res.call_number = num;
            n_neg = dvd[OUT_WIDTH-1];
            d_neg = dvs[OUT_WIDTH-1];
            n_mag = n_neg ? (~dvd + 1'b1) : dvd;
            d_mag = d_neg ? (~dvs + 1'b1) : dvs;
            if (num != call_sel) begin
                res.status = ST_UNIMPL;
            end else if (d_mag == '0) begin
                res.status = ST_DIVZERO;
            end else begin
                q_mag = n_mag / d_mag;
                r_mag = n_mag % d_mag;
                res.quotient     = (n_neg != d_neg) ? (~q_mag + 1'b1) : q_mag;
                res.remainder    = n_neg ? (~r_mag + 1'b1) : r_mag;
                res.abs_quotient = q_mag;
                res.status       = ST_DONE;
            end
            return res;
        endfunction

        function void note_call(logic compact, logic [31:0] word,
                                logic [OUT_WIDTH-1:0] dvd, logic [OUT_WIDTH-1:0] dvs);
            answers_due.push_back(divide_outcome(compact, word, dvd, dvs));
        endfunction

        function void compare_field(string name, logic [OUT_WIDTH-1:0] want,
                                    logic [OUT_WIDTH-1:0] got);
            if (want !== got) begin
                $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(swid_result_t got);
            swid_result_t want;
            if (answers_due.size() == 0) begin
                $display("%0t unexpected result: actual q=%h r=%h aq=%h st=%0d call=%h",
                         $time, got.quotient, got.remainder, got.abs_quotient,
                         got.status, got.call_number);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            compare_field("quotient", want.quotient, got.quotient);
            compare_field("remainder", want.remainder, got.remainder);
            compare_field("abs_quotient", want.abs_quotient, got.abs_quotient);
            compare_field("status", OUT_WIDTH'(want.status), OUT_WIDTH'(got.status));
            compare_field("call_number", OUT_WIDTH'(want.call_number),
                          OUT_WIDTH'(got.call_number));
        endfunction
    endclass

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CALL_WIDTH-1:0]       cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_compact_mode = 1'b0;
    logic [31:0]                 s_instr_word = '0;
    logic signed [OUT_WIDTH-1:0] s_dividend = '0;
    logic signed [OUT_WIDTH-1:0] s_divisor = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [OUT_WIDTH-1:0] m_quotient;
    logic signed [OUT_WIDTH-1:0] m_remainder;
    logic [OUT_WIDTH-1:0]        m_abs_quotient;
    logic [1:0]                  m_status;
    logic [CALL_WIDTH-1:0]       m_call_number;

    // Idle odds out of ten (gaps per transaction, stalls when none runs); zero turns idling off entirely.
    int unsigned gap_odds   = 0;
    int unsigned stall_odds = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    divide_call_tracker tracker = new();

    swi_divide_service DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_compact_mode (s_compact_mode),
        .s_instr_word   (s_instr_word),
        .s_dividend     (s_dividend),
        .s_divisor      (s_divisor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_quotient     (m_quotient),
        .m_remainder    (m_remainder),
        .m_abs_quotient (m_abs_quotient),
        .m_status       (m_status),
        .m_call_number  (m_call_number)
    );

    always #5 aclk = ~aclk;

    // Hard stop: a hung handshake must not run forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drop m_ready in bursts of random length; one assignment per edge.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, 10) <= stall_odds) begin
            stall_left <= $urandom_range(0, 11);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check every result transaction; values read here are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result('{m_quotient, m_remainder, m_abs_quotient,
                                   m_status, m_call_number});
        end
    end

    // Place a call number where the decoder looks for it in the given mode.
    function automatic logic [31:0] call_word(logic compact, logic [CALL_WIDTH-1:0] num,
                                              logic [31:0] filler);
        logic [31:0] w;
        w = filler;
        if (compact) begin
            w[CALL_WIDTH-1:0] = num;
        end else begin
            w[CALL_LSB_WORD +: CALL_WIDTH] = num;
        end
        return w;
    endfunction

    // Mix of full-range, small, shifted and extreme operand values.
    function automatic logic [OUT_WIDTH-1:0] pick_operand();
        logic [OUT_WIDTH-1:0] v;
        int                   small_val;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4: begin
                small_val = int'($urandom_range(0, 600)) - 300;
                v = small_val;
            end
            5, 6: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) begin
                    v = ~v + 1'b1;
                end
            end
            7: begin
                small_val = int'($urandom_range(0, 40)) - 20;
                v = small_val;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = MINUS_ONE;
                    3: v = '0;
                    default: v = 32'd1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Present one call transaction, hold it until accepted, then note it.
    task automatic send_call(logic compact, logic [31:0] word,
                             logic [OUT_WIDTH-1:0] dvd, logic [OUT_WIDTH-1:0] dvs);
        if (gap_odds != 0 && $urandom_range(1, 10) <= gap_odds) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_compact_mode <= compact;
        s_instr_word   <= word;
        s_dividend     <= dvd;
        s_divisor      <= dvs;
        do @(posedge aclk); while (!s_ready);
        tracker.note_call(compact, word, dvd, dvs);
    endtask

    // Stop sending and hold until every owed result has arrived.
    task automatic drain_calls();
        s_valid <= 1'b0;
        while (tracker.answers_due.size() != 0) @(posedge aclk);
    endtask

    // Write the divide call select; only called with the block empty.
    task automatic write_call_select(logic [CALL_WIDTH-1:0] num);
        cfg_valid <= 1'b1;
        cfg_data  <= num;
        do @(posedge aclk); while (!cfg_ready);
        tracker.call_sel = num;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_calls(int count, bit calm);
        logic        compact;
        logic [31:0] word;
        for (int i = 0; i < count; i++) begin
            // Re-roll idling now and then so calm stretches appear too.
            if (i % 40 == 0) begin
                gap_odds   = calm ? 0 : $urandom_range(0, 4);
                stall_odds = calm ? 0 : $urandom_range(0, 4);
            end
            compact = 1'($urandom_range(0, 1));
            word    = $urandom;
            // Mostly well-formed divide calls; the rest carry a random word that usually decodes to another number.
            if ($urandom_range(0, 9) < 8) begin
                word = call_word(compact, tracker.call_sel, word);
            end
            send_call(compact, word, pick_operand(), pick_operand());
        end
    endtask

    initial begin
        logic [CALL_WIDTH-1:0] select_plan [5];
        select_plan[0] = '0;
        select_plan[1] = '1;
        select_plan[2] = CALL_WIDTH'($urandom_range(1, 254));
        select_plan[3] = CALL_WIDTH'($urandom_range(1, 254));
        select_plan[4] = CALL_NUMBER_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed corners against the reset call select.
        gap_odds   = 2;
        stall_odds = 2;
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), 32'd100, 32'd7);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), -32'sd100, 32'd7);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), 32'd100, -32'sd7);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), -32'sd100, -32'sd7);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'hFFFF_FFFF), MOST_NEG, MINUS_ONE);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), MOST_NEG, 32'd1);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), MOST_POS, MINUS_ONE);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), MOST_NEG, MOST_NEG);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), MOST_POS, MOST_NEG);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), 32'd5, MOST_NEG);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), MOST_NEG, 32'd2);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), MINUS_ONE, 32'd2);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), MOST_POS, MOST_POS);
        // Zero divisor, including zero over zero, then a zero dividend.
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), 32'd7, 32'd0);
        send_call(1'b1, call_word(1'b1, 8'd6, 32'h0), 32'd0, 32'd0);
        send_call(1'b0, call_word(1'b0, 8'd6, 32'h0), 32'd0, 32'd5);
        // Compact mode ignores the upper halfword.
        send_call(1'b1, call_word(1'b1, 8'd6, 32'hFFFF_FF00), 32'd12345, -32'sd11);
        send_call(1'b1, call_word(1'b1, 8'd6, 32'hA5C3_0000), MOST_NEG, MINUS_ONE);
        // Number in the wrong byte for the mode: unimplemented.
        send_call(1'b1, call_word(1'b0, 8'd6, 32'h0000_0007), 32'd9, 32'd3);
        send_call(1'b0, call_word(1'b1, 8'd6, 32'h0007_0000), 32'd9, 32'd3);
        // Unimplemented call wins over a zero divisor.
        send_call(1'b0, call_word(1'b0, 8'd200, 32'h0), 32'd9, 32'd0);
        send_call(1'b1, 32'hFFFF_FFFF, MOST_NEG, MINUS_ONE);

        // Random phases, each under a new call select; the last runs with no
        // idling. Draining before every write also exercises a full pause.
        for (int p = 0; p < 5; p++) begin
            drain_calls();
            write_call_select(select_plan[p]);
            random_calls(PHASE_ITEMS, p == 4);
        end

        drain_calls();
        repeat (LATENCY + 8) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
